@@ hw/rtl/ipg_pkg.sv @@
// Package: shared constants, controller states and the result record.
package ipg_pkg;

    localparam int MAX_PARTS_DEF = 16;
    localparam int IN_W          = 5;
    localparam int OUT_W         = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FILL,
        S_EMIT_RD,
        S_EMIT_WR,
        S_DONE
    } ipg_state_t;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic [OUT_W-1:0] position;
        logic             last;
        logic             done;
    } ipg_res_t;

endpackage

@@ hw/rtl/ipg_mem.sv @@
// Parts memory: one write port and one read port with registered read data.
module ipg_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ipg_out.sv @@
// Output register stage: holds one result until the downstream side takes it.
module ipg_out (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  ipg_pkg::ipg_res_t       res,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [ipg_pkg::OUT_W-1:0] part_value,
    output logic [ipg_pkg::OUT_W-1:0] part_position,
    output logic                    last_part,
    output logic                    done_res,
    output logic                    free
);

    import ipg_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ipg_res_t res_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign part_value    = res_reg.value;
    assign part_position = res_reg.position;
    assign last_part     = res_reg.last;
    assign done_res      = res_reg.done;

endmodule

@@ hw/rtl/ipg_ctrl.sv @@
// Sequencer: scans, refills and reads out the partition held in the parts memory.
module ipg_ctrl #(
    parameter int MAX_PARTS = ipg_pkg::MAX_PARTS_DEF,
    parameter int VW        = $clog2(MAX_PARTS + 1),
    parameter int IW        = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     restart,
    input  logic [ipg_pkg::IN_W-1:0] n_value,
    output logic                     mem_we,
    output logic [IW-1:0]            mem_waddr,
    output logic [VW-1:0]            mem_wdata,
    output logic                     mem_re,
    output logic [IW-1:0]            mem_raddr,
    input  logic [VW-1:0]            mem_rdata,
    input  logic                     out_free,
    output logic                     out_load,
    output ipg_pkg::ipg_res_t        out_res
);

    import ipg_pkg::*;

    localparam int NW = (VW > IN_W) ? VW : IN_W;
    localparam logic [VW-1:0] MAX_V = VW'(MAX_PARTS);
    localparam logic [VW-1:0] ONE_V = VW'(1);

    ipg_state_t    state_reg;
    ipg_state_t    state_next;
    logic [VW-1:0] count_reg;
    logic [VW-1:0] count_next;
    logic [VW-1:0] scan_reg;
    logic [VW-1:0] scan_next;
    logic [VW-1:0] k_reg;
    logic [VW-1:0] k_next;
    logic [VW-1:0] v_reg;
    logic [VW-1:0] v_next;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] rem_next;
    logic          finished_reg;
    logic          finished_next;

    logic          accept;
    logic [NW-1:0] n_wide;
    logic [VW-1:0] n_sat;
    logic          n_zero;
    logic [VW-1:0] scan_m1;
    logic [VW-1:0] k_p1;
    logic          is_last;
    logic          part_big;
    logic          room;

    assign accept   = (state_reg == S_IDLE) && in_valid;
    assign n_wide   = NW'(n_value);
    assign n_sat    = (n_wide > NW'(MAX_PARTS)) ? MAX_V : VW'(n_wide);
    assign n_zero   = (n_value == '0);
    assign scan_m1  = scan_reg - ONE_V;
    assign k_p1     = k_reg + ONE_V;
    assign is_last  = (k_p1 == count_reg);
    assign part_big = (mem_rdata > ONE_V);
    assign room     = (count_reg < MAX_V);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        state_next = n_zero ? S_DONE : S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = finished_reg ? S_DONE : S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = (scan_reg == '0) ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                state_next = part_big ? S_FILL : S_SCAN_RD;
            end
            S_FILL:
            begin
                if (!room || (rem_reg < v_reg && rem_reg == '0))
                begin
                    state_next = S_EMIT_RD;
                end
                else if (rem_reg < v_reg)
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (out_free)
                begin
                    state_next = is_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        count_next    = count_reg;
        scan_next     = scan_reg;
        k_next        = k_reg;
        v_next        = v_reg;
        rem_next      = rem_reg;
        finished_next = finished_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    k_next    = '0;
                    scan_next = count_reg;
                    if (restart)
                    begin
                        finished_next = n_zero;
                        count_next    = n_zero ? '0 : ONE_V;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (scan_reg == '0)
                begin
                    finished_next = 1'b1;
                end
            end
            S_SCAN_CHK:
            begin
                if (part_big)
                begin
                    // The freed units are the trailing ones plus the unit taken off.
                    v_next     = mem_rdata - ONE_V;
                    rem_next   = count_reg - scan_reg + ONE_V;
                    count_next = scan_reg;
                end
                else
                begin
                    scan_next = scan_m1;
                end
            end
            S_FILL:
            begin
                if (room && rem_reg >= v_reg)
                begin
                    count_next = count_reg + ONE_V;
                    rem_next   = rem_reg - v_reg;
                end
                else if (room && rem_reg != '0)
                begin
                    count_next = count_reg + ONE_V;
                    rem_next   = '0;
                end
            end
            S_EMIT_WR:
            begin
                if (out_free && !is_last)
                begin
                    k_next = k_p1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs: handshake, memory control and the result record.
    always_comb
    begin
        in_stall         = (state_reg != S_IDLE);
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        out_load         = 1'b0;
        out_res.value    = '0;
        out_res.position = '0;
        out_res.last     = 1'b1;
        out_res.done     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && restart && !n_zero)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = n_sat;
                end
            end
            S_SCAN_RD:
            begin
                mem_re    = (scan_reg != '0);
                mem_raddr = scan_m1[IW-1:0];
            end
            S_SCAN_CHK:
            begin
                mem_we    = part_big;
                mem_waddr = scan_m1[IW-1:0];
                mem_wdata = mem_rdata - ONE_V;
            end
            S_FILL:
            begin
                mem_we    = room && (rem_reg != '0);
                mem_waddr = count_reg[IW-1:0];
                mem_wdata = (rem_reg >= v_reg) ? v_reg : rem_reg;
            end
            S_EMIT_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = k_reg[IW-1:0];
            end
            S_EMIT_WR:
            begin
                out_load         = out_free;
                out_res.value    = OUT_W'(mem_rdata);
                out_res.position = OUT_W'(k_p1);
                out_res.last     = is_last;
                out_res.done     = 1'b0;
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            finished_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        k_reg    <= k_next;
        v_reg    <= v_next;
        rem_reg  <= rem_next;
    end

endmodule

@@ hw/rtl/integer_partition_generator.sv @@
// Integer partition generator: enumerates the partitions of n in reverse
// lexicographic order, one part per result. A request with restart set loads
// n_value (saturated to MAX_PARTS) and returns the single part n, or one done
// result if n is zero; each request without restart returns the next
// partition, or one done result once none is left. Requests are taken one at
// a time; a new one is taken while the final result of the previous one still
// waits in the output register. An advance scans back over the trailing parts,
// refills and then emits every part in order; every read goes through the
// single read port of the parts memory, whose read data is registered.
module integer_partition_generator #(
    parameter int MAX_PARTS = ipg_pkg::MAX_PARTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      restart,
    input  logic [ipg_pkg::IN_W-1:0]  n_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [ipg_pkg::OUT_W-1:0] part_value,
    output logic [ipg_pkg::OUT_W-1:0] part_position,
    output logic                      last_part,
    output logic                      done_res
);

    import ipg_pkg::*;

    localparam int VW = $clog2(MAX_PARTS + 1);
    localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [VW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [VW-1:0] mem_rdata;
    logic          out_free;
    logic          out_load;
    ipg_res_t      out_res;

    ipg_ctrl #(
        .MAX_PARTS (MAX_PARTS),
        .VW        (VW),
        .IW        (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .n_value   (n_value),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_res   (out_res)
    );

    ipg_mem #(
        .DEPTH (MAX_PARTS),
        .AW    (IW),
        .DW    (VW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ipg_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .res           (out_res),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .part_value    (part_value),
        .part_position (part_position),
        .last_part     (last_part),
        .done_res      (done_res),
        .free          (out_free)
    );

endmodule

@@ hw/rtl/ipg_checker.sv @@
// Port checker for the partition generator, bound to the top level.
module ipg_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [ipg_pkg::OUT_W-1:0] part_value,
    input logic [ipg_pkg::OUT_W-1:0] part_position,
    input logic                      last_part,
    input logic                      done_res
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(part_value)
            && $stable(part_position) && $stable(last_part) && $stable(done_res))
        else $error("stalled result changed");

    // A done result carries no part and closes its request.
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> part_value == '0 && part_position == '0 && last_part)
        else $error("malformed done result");

    // Every real part has a non-zero value and a position counted from one.
    a_part_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> part_value != '0 && part_position != '0)
        else $error("part result with zero value or position");

endmodule

bind integer_partition_generator ipg_checker u_ipg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .part_value    (part_value),
    .part_position (part_position),
    .last_part     (last_part),
    .done_res      (done_res)
);
